### design/radial_ripple_pixel_overlay_top_macros.svh
// Assertion macros for the radial ripple pixel overlay.
// Used by the checker that is bound to the top level.
`ifndef RADIAL_RIPPLE_PIXEL_OVERLAY_TOP_MACROS_SVH
`define RADIAL_RIPPLE_PIXEL_OVERLAY_TOP_MACROS_SVH

// condition holds at every clock edge outside reset
`define RRPO_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define RRPO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/rrpo_pkg.sv
// Shared constants, register codes and helpers of the radial ripple overlay.
// No dependencies.
`default_nettype none
package rrpo_pkg;

	localparam int COORD_BITS_DEF   = 12;
	localparam int SINE_ENTRIES_DEF = 1024;

	localparam int PERIOD_Q4        = 1920;
	localparam int RECIP15          = 4369;
	localparam int SEVEN_TENTHS_Q15 = 22938;
	localparam int GAIN             = 300;
	localparam int SHIFT_BITS       = 11;
	localparam int FRAME_BITS       = 24;
	localparam int APB_ADDR_BITS    = 5;

	typedef enum logic [2:0] {
		REG_BOX_LEFT,
		REG_BOX_TOP,
		REG_BOX_WIDTH,
		REG_BOX_HEIGHT,
		REG_FRAME_COUNT
	} reg_idx_t;

	typedef struct packed {
		logic push;
		logic busy;
	} q_ctrl_t;

	// 80 * (frame mod 24), frame mod 24 = 8 * ((frame >> 3) mod 3) + frame[2:0]
	function automatic logic [SHIFT_BITS-1:0] frame_shift(input logic [FRAME_BITS-1:0] fc);
		logic [5:0] dsum;
		logic [3:0] s2;
		logic [2:0] s3;
		logic [1:0] m3;
		logic [21:0] y;
		logic [4:0] fmod;
		y = {1'b0, fc[FRAME_BITS-1:3]};
		dsum = '0;
		for (int i = 0; i < 11; i++) begin
			dsum = dsum + {4'b0, y[2*i +: 2]};
		end
		s2 = {2'b0, dsum[5:4]} + {2'b0, dsum[3:2]} + {2'b0, dsum[1:0]};
		s3 = {1'b0, s2[3:2]} + {1'b0, s2[1:0]};
		m3 = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
		fmod = {m3, fc[2:0]};
		return SHIFT_BITS'(fmod) * SHIFT_BITS'(80);
	endfunction

endpackage
`default_nettype wire

### design/rrpo_cfg.sv
// APB register file: face box and frame count, with derived ripple centre and phase shift.
// Depends on rrpo_pkg.
`default_nettype none
module rrpo_cfg import rrpo_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready,
	output logic      [COORD_BITS:0]      cx,
	output logic      [COORD_BITS:0]      cy,
	output logic      [SHIFT_BITS-1:0]    shift
);

	logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q, hdiv3_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [SHIFT_BITS-1:0] shift_q;
	logic                  wr_en;
	reg_idx_t              idx;
	logic [COORD_BITS+16:0] hprod;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign hprod  = pwdata[COORD_BITS-1:0] * 17'd43691;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			hdiv3_q  <= '0;
			frame_q  <= '0;
			shift_q  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BOX_LEFT:   left_q <= pwdata[COORD_BITS-1:0];
				REG_BOX_TOP:    top_q <= pwdata[COORD_BITS-1:0];
				REG_BOX_WIDTH:  width_q <= pwdata[COORD_BITS-1:0];
				REG_BOX_HEIGHT: begin
					height_q <= pwdata[COORD_BITS-1:0];
					hdiv3_q  <= hprod[COORD_BITS+16:17];
				end
				REG_FRAME_COUNT: begin
					frame_q <= pwdata[FRAME_BITS-1:0];
					shift_q <= frame_shift(pwdata[FRAME_BITS-1:0]);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BOX_LEFT:    prdata = 32'(left_q);
			REG_BOX_TOP:     prdata = 32'(top_q);
			REG_BOX_WIDTH:   prdata = 32'(width_q);
			REG_BOX_HEIGHT:  prdata = 32'(height_q);
			REG_FRAME_COUNT: prdata = 32'(frame_q);
			default:         prdata = '0;
		endcase
	end

	assign cx    = {1'b0, left_q} + {2'b0, width_q[COORD_BITS-1:1]};
	assign cy    = {1'b0, top_q} + {1'b0, hdiv3_q};
	assign shift = shift_q;

endmodule
`default_nettype wire

### design/rrpo_front.sv
// Front end: accepts pixels, forms offsets to the ripple centre and the squared distance.
// Depends on rrpo_pkg.
`default_nettype none
module rrpo_front import rrpo_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [COORD_BITS-1:0]   pixel_col,
	input  wire logic [COORD_BITS-1:0]   pixel_row,
	input  wire logic [23:0]             rgb,
	input  wire logic [COORD_BITS:0]     cx,
	input  wire logic [COORD_BITS:0]     cy,
	output logic                         push,
	output logic      [2*COORD_BITS+2:0] sq,
	output logic      [23:0]             push_rgb
);

	localparam int DW = COORD_BITS + 2;

	logic                   v_s1, v_s2;
	logic signed [DW-1:0]   dx_s1, dy_s1;
	logic [23:0]            rgb_s1, rgb_s2;
	logic [2*COORD_BITS+2:0] sq_s2;
	logic signed [2*DW-1:0] px, py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		dx_s1  <= $signed({2'b0, pixel_col} - {1'b0, cx});
		dy_s1  <= $signed({2'b0, pixel_row} - {1'b0, cy});
		rgb_s1 <= rgb;
		sq_s2  <= px[2*COORD_BITS+2:0] + py[2*COORD_BITS+2:0];
		rgb_s2 <= rgb_s1;
	end

	assign push     = v_s2;
	assign sq       = sq_s2;
	assign push_rgb = rgb_s2;

endmodule
`default_nettype wire

### design/rrpo_queue.sv
// Short queue between front and back end.
// Depends on rrpo_pkg.
`default_nettype none
module rrpo_queue import rrpo_pkg::*; #(
	parameter int WIDTH = 2 * COORD_BITS_DEF + 27
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  q_ctrl_t               ctrl_in,
	output q_ctrl_t               ctrl_out,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  rvalid,
	output logic      [WIDTH-1:0] rdata
);

	localparam int DEPTH = 4;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [1:0]       wptr_q, rptr_q;
	logic [2:0]       count_q;
	logic             pop;

	assign rvalid = (count_q != 3'd0);
	assign pop    = rvalid;
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl_in.push) wptr_q <= wptr_q + 2'd1;
			if (pop) rptr_q <= rptr_q + 2'd1;
			count_q <= count_q + {2'b0, ctrl_in.push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_in.push) mem_q[wptr_q] <= wdata;
	end

	assign ctrl_out.push = pop;
	assign ctrl_out.busy = (count_q >= 3'd2);

endmodule
`default_nettype wire

### design/rrpo_back.sv
// Back end: pipelined square root, phase, sine level lookup and saturating add.
// Depends on rrpo_pkg.
`default_nettype none
module rrpo_back import rrpo_pkg::*; #(
	parameter int COORD_BITS         = COORD_BITS_DEF,
	parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic [2*COORD_BITS+2:0] sq,
	input  wire logic [23:0]             rgb,
	input  wire logic [SHIFT_BITS-1:0]   shift,
	output logic                         done,
	output logic      [7:0]              out_blue,
	output logic      [7:0]              out_green,
	output logic      [7:0]              out_red,
	output logic      [7:0]              ripple_level
);

	localparam int RW = COORD_BITS + 6;
	localparam int VW = 2 * RW;
	localparam int XW = RW - 7;
	localparam int IW = $clog2(SINE_TABLE_ENTRIES);
	localparam int YW = SHIFT_BITS + $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int ZW = YW - 7;
	localparam int QW = ZW - 3;

	typedef logic [7:0] lvl_rom_t [SINE_TABLE_ENTRIES];

	function automatic lvl_rom_t build_rom();
		lvl_rom_t rom;
		logic [63:0] kk, ang, x2, term, tmp, mag;
		logic signed [63:0] sum, sv, diff, lv;
		logic neg;
		for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
			kk = 64'(k);
			neg = 1'b0;
			if (2 * kk > 64'(SINE_TABLE_ENTRIES)) begin
				kk = 64'(SINE_TABLE_ENTRIES) - kk;
				neg = 1'b1;
			end
			ang = (kk * 64'd6746518852 + 64'(SINE_TABLE_ENTRIES / 2))
				/ 64'(SINE_TABLE_ENTRIES);
			if (ang > 64'd1686629713)
				ang = (ang > 64'd3373259426) ? 64'd0 : 64'd3373259426 - ang;
			x2 = (ang * ang) >> 30;
			term = ang;
			sum = $signed(ang);
			for (int i = 1; i <= 7; i++) begin
				tmp = (term * x2) >> 30;
				case (i)
					1: term = tmp / 64'd6;
					2: term = tmp / 64'd20;
					3: term = tmp / 64'd42;
					4: term = tmp / 64'd72;
					5: term = tmp / 64'd110;
					6: term = tmp / 64'd156;
					default: term = tmp / 64'd210;
				endcase
				if (i % 2 == 1) sum = sum - $signed(term);
				else sum = sum + $signed(term);
			end
			if (sum < 0) sum = 0;
			mag = (64'(sum) + 64'd16384) >> 15;
			if (mag > 64'd32767) mag = 64'd32767;
			sv = neg ? -$signed(mag) : $signed(mag);
			diff = sv - 64'sd22938;
			rom[k] = 8'd0;
			if (diff > 0) begin
				lv = (diff * 64'sd300 + 64'sd16384) >>> 15;
				rom[k] = (lv > 64'sd255) ? 8'd255 : 8'(lv);
			end
		end
		return rom;
	endfunction

	localparam lvl_rom_t LVL_ROM = build_rom();

	logic          ok_s  [RW+1];
	logic [VW-1:0] rem_s [RW+1];
	logic [VW-1:0] rt_s  [RW+1];
	logic [23:0]   rgb_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok_s[0] <= 1'b0;
		else ok_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= VW'({sq, 8'h00});
		rt_s[0]  <= '0;
		rgb_s[0] <= rgb;
	end

	for (genvar k = 0; k < RW; k++) begin : g_root
		localparam logic [VW-1:0] BIT = VW'(1) << (2 * (RW - 1 - k));
		logic [VW-1:0] trial;
		assign trial = rt_s[k] + BIT;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ok_s[k+1] <= 1'b0;
			else ok_s[k+1] <= ok_s[k];
		end
		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial;
				rt_s[k+1]  <= (rt_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_s[k];
				rt_s[k+1]  <= rt_s[k] >> 1;
			end
			rgb_s[k+1] <= rgb_s[k];
		end
	end

	logic          pok_s  [1:7];
	logic [23:0]   prgb_s [1:7];

	logic [RW-1:0]         d16;
	logic [XW+12:0]        p1;
	logic [RW-1:0]         d16_s1;
	logic [XW-4:0]         q1_s1;
	logic [RW-1:0]         r1;
	logic [SHIFT_BITS-1:0] r_s2;
	logic [SHIFT_BITS:0]   t3;
	logic [SHIFT_BITS-1:0] t3m;
	logic [YW-1:0]         y3;
	logic [ZW-1:0]         z_s3, z_s4;
	logic [ZW+12:0]        p4;
	logic [QW-1:0]         q2_s4;
	logic [ZW-1:0]         r5;
	logic [QW:0]           q5;
	logic [IW-1:0]         idx_s5;
	logic [7:0]            lvl_s6;
	logic [8:0]            sb, sg, sr;
	logic [7:0]            blue_s7, green_s7, red_s7, lvl_s7;

	assign d16 = rt_s[RW][RW-1:0];
	assign p1  = d16[RW-1:7] * 13'(RECIP15);
	assign r1  = d16_s1 - RW'(q1_s1) * RW'(PERIOD_Q4);
	assign t3  = {1'b0, r_s2} + (SHIFT_BITS+1)'(PERIOD_Q4) - {1'b0, shift};
	assign t3m = (t3 >= (SHIFT_BITS+1)'(PERIOD_Q4)) ?
		SHIFT_BITS'(t3 - (SHIFT_BITS+1)'(PERIOD_Q4)) : t3[SHIFT_BITS-1:0];
	assign y3  = YW'(t3m) * YW'(SINE_TABLE_ENTRIES);
	assign p4  = z_s3 * 13'(RECIP15);
	assign r5  = z_s4 - ZW'(q2_s4) * ZW'(15);
	assign q5  = (r5 >= ZW'(15)) ? {1'b0, q2_s4} + (QW+1)'(1) : {1'b0, q2_s4};
	assign sb  = {1'b0, prgb_s[6][7:0]} + {1'b0, lvl_s6};
	assign sg  = {1'b0, prgb_s[6][15:8]} + {1'b0, lvl_s6};
	assign sr  = {1'b0, prgb_s[6][23:16]} + {1'b0, lvl_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 7; i++) pok_s[i] <= 1'b0;
		end else begin
			pok_s[1] <= ok_s[RW];
			for (int i = 2; i <= 7; i++) pok_s[i] <= pok_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		prgb_s[1] <= rgb_s[RW];
		for (int i = 2; i <= 7; i++) prgb_s[i] <= prgb_s[i-1];
		d16_s1 <= d16;
		q1_s1  <= p1[XW+12:16];
		r_s2   <= (r1 >= RW'(PERIOD_Q4)) ? SHIFT_BITS'(r1 - RW'(PERIOD_Q4)) :
			r1[SHIFT_BITS-1:0];
		z_s3   <= y3[YW-1:7];
		z_s4   <= z_s3;
		q2_s4  <= p4[ZW+12:16];
		idx_s5 <= (q5 >= (QW+1)'(SINE_TABLE_ENTRIES)) ?
			IW'(SINE_TABLE_ENTRIES - 1) : IW'(q5);
		lvl_s6 <= LVL_ROM[idx_s5];
		blue_s7  <= sb[8] ? 8'hFF : sb[7:0];
		green_s7 <= sg[8] ? 8'hFF : sg[7:0];
		red_s7   <= sr[8] ? 8'hFF : sr[7:0];
		lvl_s7   <= lvl_s6;
	end

	assign done         = pok_s[7];
	assign out_blue     = blue_s7;
	assign out_green    = green_s7;
	assign out_red      = red_s7;
	assign ripple_level = lvl_s7;

endmodule
`default_nettype wire

### design/radial_ripple_pixel_overlay_top.sv
// Top level of the radial ripple pixel overlay.
// Depends on rrpo_pkg, rrpo_cfg, rrpo_front, rrpo_queue and rrpo_back.
//
// Usage:
//   Configure the face box (left, top, width, height) and the frame count over the
//   APB port while no pixel is in flight; pready is always high.
//   Present a pixel on pixel_col, pixel_row, in_blue, in_green, in_red with start high;
//   it is taken at each edge where start is high and busy is low.
//   One pixel per cycle is sustained; busy does not rise while results drain freely.
//   Each result appears on out_blue, out_green, out_red and ripple_level for one cycle
//   with done high, after the pixel has passed the front end, the queue and the back end.
//   The back end is the square root pipeline, one root bit per stage, followed
//   by the phase reduction, sine level table lookup and saturating add.
//   Results leave in input order; the receiver cannot stall them.
//   Reset clears the configuration registers and the valid bits, emptying the pipeline;
//   the data registers are not reset; the level table is constant and needs no fill.
`default_nettype none
module radial_ripple_pixel_overlay_top import rrpo_pkg::*; #(
	parameter int COORD_BITS         = COORD_BITS_DEF,
	parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [COORD_BITS-1:0]    pixel_col,
	input  wire logic [COORD_BITS-1:0]    pixel_row,
	input  wire logic [7:0]               in_blue,
	input  wire logic [7:0]               in_green,
	input  wire logic [7:0]               in_red,
	output logic                          done,
	output logic      [7:0]               out_blue,
	output logic      [7:0]               out_green,
	output logic      [7:0]               out_red,
	output logic      [7:0]               ripple_level
);

	localparam int SQW = 2 * COORD_BITS + 3;

	logic [COORD_BITS:0]   cx, cy;
	logic [SHIFT_BITS-1:0] shift;
	logic                  push;
	logic [SQW-1:0]        sq;
	logic [23:0]           push_rgb;
	q_ctrl_t               q_in, q_out;
	logic                  rvalid;
	logic [SQW+23:0]       rdata;

	rrpo_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cx(cx), .cy(cy), .shift(shift)
	);

	rrpo_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy),
		.pixel_col(pixel_col), .pixel_row(pixel_row), .rgb({in_red, in_green, in_blue}),
		.cx(cx), .cy(cy), .push(push), .sq(sq), .push_rgb(push_rgb)
	);

	assign q_in.push = push;
	assign q_in.busy = 1'b0;

	rrpo_queue #(.WIDTH(SQW + 24)) u_queue (
		.clk(clk), .arst_n(arst_n), .ctrl_in(q_in), .ctrl_out(q_out),
		.wdata({sq, push_rgb}), .rvalid(rvalid), .rdata(rdata)
	);

	assign busy = q_out.busy && !q_out.push;

	rrpo_back #(.COORD_BITS(COORD_BITS), .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(rvalid), .sq(rdata[SQW+23:24]),
		.rgb(rdata[23:0]), .shift(shift), .done(done), .out_blue(out_blue),
		.out_green(out_green), .out_red(out_red), .ripple_level(ripple_level)
	);

endmodule
`default_nettype wire

### design/rrpo_checker.sv
// Port-level checker for the radial ripple overlay, bound to the top level.
// Depends on rrpo_pkg and radial_ripple_pixel_overlay_top_macros.svh.
`default_nettype none
`include "radial_ripple_pixel_overlay_top_macros.svh"
module rrpo_checker import rrpo_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       pready,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [7:0] out_blue,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_red,
	input wire logic [7:0] ripple_level
);

	`RRPO_ASSERT_ALWAYS(a_pready_high, clk, arst_n, pready, "pready dropped")
	`RRPO_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy, "busy raised with free-running output")
	`RRPO_ASSERT_IMPL(a_sat_add, clk, arst_n, done,
		(out_blue >= ripple_level) && (out_green >= ripple_level) &&
		(out_red >= ripple_level), "channel below ripple level")

endmodule

bind radial_ripple_pixel_overlay_top rrpo_checker u_rrpo_checker (
	.clk(clk), .arst_n(arst_n), .pready(pready), .busy(busy), .done(done),
	.out_blue(out_blue), .out_green(out_green), .out_red(out_red),
	.ripple_level(ripple_level)
);
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for radial_ripple_pixel_overlay_top.
// Uses rrpo_pkg; a scoreboard class predicts each overlaid pixel from the box and frame setup.
`default_nettype none
module tb;
	import rrpo_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 28;
	localparam int UNUSED_REG_IDX = 5;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] level;
	} overlay_t;

	class ripple_scoreboard;
		int sine_q15[SINE_ENTRIES_DEF];
		bit [11:0] box_left, box_top, box_width, box_height;
		bit [23:0] frame;
		overlay_t pending[$];
		int errors;

		function new();
			for (int k = 0; k < SINE_ENTRIES_DEF; k++)
				sine_q15[k] = sine_value(k);
			errors = 0;
		endfunction

		function int sine_value(int unsigned k);
			longint unsigned n, ang, x2, term, mag;
			longint sum;
			bit neg;
			n = SINE_ENTRIES_DEF;
			neg = 0;
			if (2 * longint'(k) > n) begin
				k = 32'(n - k);
				neg = 1;
			end
			ang = (longint'(k) * 64'd6746518852 + n / 2) / n;
			if (ang > 64'd1686629713)
				ang = (ang > 64'd3373259426) ? 0 : 64'd3373259426 - ang;
			x2 = (ang * ang) >> 30;
			term = ang;
			sum = ang;
			for (int i = 1; i <= 7; i++) begin
				term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
				if (i & 1)
					sum -= term;
				else
					sum += term;
			end
			if (sum < 0)
				sum = 0;
			mag = (longint'(sum) + 16384) >> 15;
			if (mag > 32767)
				mag = 32767;
			return neg ? -int'(mag) : int'(mag);
		endfunction

		function void write_reg(int idx, bit [31:0] value);
			case (idx)
				REG_BOX_LEFT:    box_left = value[11:0];
				REG_BOX_TOP:     box_top = value[11:0];
				REG_BOX_WIDTH:   box_width = value[11:0];
				REG_BOX_HEIGHT:  box_height = value[11:0];
				REG_FRAME_COUNT: frame = value[23:0];
				default: ;
			endcase
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function logic [7:0] sat_add(logic [7:0] a, int b);
			int s;
			s = a + b;
			return (s > 255) ? 8'd255 : s[7:0];
		endfunction

		function void note_pixel(logic [11:0] col, logic [11:0] row,
				logic [7:0] b, logic [7:0] g, logic [7:0] r);
			longint dx, dy, shift, phase, idx;
			longint unsigned d16;
			int diff, lvl;
			overlay_t o;
			dx = longint'(col) - (longint'(box_left) + box_width / 2);
			dy = longint'(row) - (longint'(box_top) + box_height / 3);
			d16 = root((dx * dx + dy * dy) * 256);
			shift = 80 * (frame % 24);
			phase = (longint'(d16 % PERIOD_Q4) + PERIOD_Q4 - shift) % PERIOD_Q4;
			idx = phase * SINE_ENTRIES_DEF / PERIOD_Q4;
			if (idx >= SINE_ENTRIES_DEF)
				idx = SINE_ENTRIES_DEF - 1;
			diff = sine_q15[idx] - SEVEN_TENTHS_Q15;
			lvl = 0;
			if (diff > 0) begin
				lvl = (diff * GAIN + 16384) >>> 15;
				if (lvl > 255)
					lvl = 255;
			end
			o.blue = sat_add(b, lvl);
			o.green = sat_add(g, lvl);
			o.red = sat_add(r, lvl);
			o.level = lvl[7:0];
			pending = {pending, o};
		endfunction

		function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r,
				logic [7:0] lvl);
			overlay_t o;
			if (pending.size() == 0) begin
				$error("result with no pixel pending");
				errors++;
				return;
			end
			o = pending.pop_front();
			if (b !== o.blue) begin
				$error("out_blue expected %0d actual %0d", o.blue, b);
				errors++;
			end
			if (g !== o.green) begin
				$error("out_green expected %0d actual %0d", o.green, g);
				errors++;
			end
			if (r !== o.red) begin
				$error("out_red expected %0d actual %0d", o.red, r);
				errors++;
			end
			if (lvl !== o.level) begin
				$error("ripple_level expected %0d actual %0d", o.level, lvl);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic [11:0] pixel_col = '0, pixel_row = '0;
	logic [7:0] in_blue = '0, in_green = '0, in_red = '0;
	logic done;
	logic [7:0] out_blue, out_green, out_red, ripple_level;

	ripple_scoreboard sb = new();
	int idle_pct;

	radial_ripple_pixel_overlay_top uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_pixel(pixel_col, pixel_row, in_blue, in_green, in_red);
		if (arst_n && done)
			sb.check_result(out_blue, out_green, out_red, ripple_level);
	end

	task automatic write_reg(int idx, bit [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= APB_ADDR_BITS'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic setup_box(int l, int t, int w, int h, int f);
		write_reg(REG_BOX_LEFT, l);
		write_reg(REG_BOX_TOP, t);
		write_reg(REG_BOX_WIDTH, w);
		write_reg(REG_BOX_HEIGHT, h);
		write_reg(REG_FRAME_COUNT, f);
	endtask

	task automatic send_pixel(int c, int r, int b, int g, int rd);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1;
		pixel_col <= 12'(c);
		pixel_row <= 12'(r);
		in_blue <= 8'(b);
		in_green <= 8'(g);
		in_red <= 8'(rd);
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic random_pixel();
		int cx, cy;
		int c, r;
		cx = int'(sb.box_left) + int'(sb.box_width) / 2;
		cy = int'(sb.box_top) + int'(sb.box_height) / 3;
		if ($urandom_range(99) < 70) begin
			c = (cx + int'($urandom_range(0, 300)) - 150) & 'hFFF;
			r = (cy + int'($urandom_range(0, 300)) - 150) & 'hFFF;
		end else begin
			c = $urandom_range(0, 4095);
			r = $urandom_range(0, 4095);
		end
		send_pixel(c, r, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int pcts[4] = '{0, 61, 0, 38};
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_pixel(0, 0, 0, 0, 0);
		send_pixel('hFFF, 'hFFF, 'hFF, 'hFF, 'hFF);
		drain();
		setup_box(100, 200, 64, 90, 0);
		write_reg(UNUSED_REG_IDX, 32'hFFFF_FFFF);
		send_pixel(132, 230, 0, 128, 255);
		for (int i = 0; i < 8; i++)
			send_pixel(132 + 2 * i, 230, 'hF0, 'h0F, 'hAA);
		send_pixel(0, 'hFFF, 255, 0, 255);
		send_pixel('hFFF, 0, 0, 255, 0);
		drain();
		setup_box('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFFFFF);
		send_pixel(0, 0, 'h55, 'hAA, 'h55);
		send_pixel('hFFF, 'hFFF, 200, 200, 200);
		send_pixel('hFFF, 'hFFF, 'hFE, 'h01, 'h80);
		drain();
		setup_box(0, 0, 0, 0, 23);
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(5, 5, 250, 1, 127);
		send_pixel('hFFF, 'hFFF, 0, 0, 0);
		drain();
		setup_box(2000, 1000, 1, 2, 24);
		send_pixel(2000, 1000, 100, 100, 100);
		send_pixel(2003, 1004, 100, 100, 100);

		for (int p = 0; p < 8; p++) begin
			drain();
			idle_pct = pcts[p % 4];
			if (p == 0)
				setup_box(0, 0, 0, 0, 0);
			else if (p == 1)
				setup_box('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFFFFF);
			else
				setup_box($urandom, $urandom, $urandom, $urandom, $urandom);
			for (int i = 0; i < 60; i++)
				random_pixel();
		end
		drain();

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
